>>> hw/rtl/lpfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lpfp_pkg;

    localparam logic [7:0]  DELIM_RESET    = 8'd36;
    localparam logic [15:0] FRAME_OVERHEAD = 16'd7;

    // Queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0]
    {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_BODY = 3'd3,
        PH_CRC  = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    typedef enum logic [1:0]
    {
        EV_NONE   = 2'd0,
        EV_BODY   = 2'd1,
        EV_ACCEPT = 2'd2,
        EV_DROP   = 2'd3
    } event_t;

    typedef enum logic
    {
        OP_DATA       = 1'b0,
        OP_LINE_ERROR = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [15:0] frame_crc;
        logic [15:0] frame_length;
        logic [7:0]  message_type;
        logic [15:0] body_index;
        logic [7:0]  body_byte;
        event_t      event_res;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser: front end, result queue, output stage.
// Depends on lpfp_pkg, lpfp_front, lpfp_queue, lpfp_back.
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tuser = operation, s_tdata = rx_byte
//  m_axis    out  m_tvalid/m_tready  m_tuser = event_res, m_tdata = result fields
//  cfg       in   cfg_wr_en          cfg_wr_data = delimiter_char
//
//  One byte is accepted per cycle while s_tready is high and gives exactly one result.
//  The result of an accepted byte is written into the two-entry queue, then loaded
//  into the output register that drives m_tvalid.
//  s_tready drops only while the queue is full behind a stalled output.
//  Reset returns the parser to hunting for the start delimiter, '$' by default.

module length_prefixed_frame_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [7:0] body_byte, [23:8] body_index,
                                        // [31:24] message_type, [47:32] frame_length,
                                        // [63:48] frame_crc
    output logic [1:0]       m_tuser,   // [1:0] event_res
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);
    import lpfp_pkg::*;

    result_t front_res;
    result_t q_data;
    result_t out_data;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    logic    in_take;

    assign s_tready = !q_full;
    assign in_take  = s_tvalid && s_tready;

    lpfp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_take     (in_take),
        .in_op       (s_tuser),
        .in_byte     (s_tdata),
        .res         (front_res)
    );

    lpfp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_take),
        .push_data (front_res),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    lpfp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (out_data)
    );

    assign m_tuser = out_data.event_res;
    assign m_tdata = {out_data.frame_crc, out_data.frame_length, out_data.message_type,
                      out_data.body_index, out_data.body_byte};

endmodule

`default_nettype wire

>>> hw/rtl/lpfp_front.sv
// Front end: accepts received bytes, tracks the frame phase, builds one result per byte.
// Depends on lpfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfp_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [7:0]        cfg_wr_data,
    input  wire logic              in_take,
    input  wire logic              in_op,
    input  wire logic [7:0]        in_byte,
    output lpfp_pkg::result_t      res
);
    import lpfp_pkg::*;

    logic [7:0]  delim_reg;
    phase_t      phase_reg, phase_next;
    logic        len_hi_reg, len_hi_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic        crc_hi_reg, crc_hi_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  type_reg, type_next;

    logic [15:0] body_len;
    logic [15:0] count_inc;
    event_t      ev;

    assign body_len  = (length_reg >= FRAME_OVERHEAD) ? (length_reg - FRAME_OVERHEAD) : 16'd0;
    assign count_inc = count_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg  <= DELIM_RESET;
            phase_reg  <= PH_HUNT;
            len_hi_reg <= 1'b0;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
            crc_hi_reg <= 1'b0;
            crc_reg    <= 16'd0;
            type_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                delim_reg <= cfg_wr_data;
            end
            if (in_take)
            begin
                phase_reg  <= phase_next;
                len_hi_reg <= len_hi_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                crc_hi_reg <= crc_hi_next;
                crc_reg    <= crc_next;
                type_reg   <= type_next;
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        len_hi_next = len_hi_reg;
        length_next = length_reg;
        count_next  = count_reg;
        crc_hi_next = crc_hi_reg;
        crc_next    = crc_reg;
        type_next   = type_reg;
        ev          = EV_NONE;
        res         = '0;

        if (in_op == OP_LINE_ERROR)
        begin
            // restart the hunt, keep captured fields
            phase_next  = PH_HUNT;
            len_hi_next = 1'b0;
            count_next  = 16'd0;
            crc_hi_next = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (!len_hi_reg)
                    begin
                        length_next = {8'd0, in_byte};
                        len_hi_next = 1'b1;
                    end
                    else
                    begin
                        length_next = {in_byte, length_reg[7:0]};
                        len_hi_next = 1'b0;
                        phase_next  = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = in_byte;
                    phase_next = (body_len != 16'd0) ? PH_BODY : PH_CRC;
                end
                PH_BODY:
                begin
                    ev               = EV_BODY;
                    res.body_byte    = in_byte;
                    res.body_index   = count_reg;
                    count_next       = count_inc;
                    if (count_inc == body_len)
                    begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    if (!crc_hi_reg)
                    begin
                        crc_next    = {8'd0, in_byte};
                        crc_hi_next = 1'b1;
                    end
                    else
                    begin
                        crc_next    = {in_byte, crc_reg[7:0]};
                        crc_hi_next = 1'b0;
                        phase_next  = PH_END;
                    end
                end
                PH_END:
                begin
                    phase_next  = PH_HUNT;
                    len_hi_next = 1'b0;
                    count_next  = 16'd0;
                    crc_hi_next = 1'b0;
                    ev          = (in_byte == delim_reg) ? EV_ACCEPT : EV_DROP;
                end
                default:
                begin
                    // hunt, and any unused phase code
                    if (in_byte == delim_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                end
            endcase
        end

        res.event_res = ev;
        if (ev != EV_NONE)
        begin
            res.message_type = type_reg;
            res.frame_length = length_reg;
        end
        if (ev == EV_ACCEPT || ev == EV_DROP)
        begin
            res.frame_crc = crc_reg;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lpfp_queue.sv
// Short result queue between the parser front end and the output stage.
// Depends on lpfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfp_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lpfp_pkg::result_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output lpfp_pkg::result_t      pop_data
);
    import lpfp_pkg::*;

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lpfp_back.sv
// Output stage: drains the result queue into a registered stream master.
// Depends on lpfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfp_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_not_empty,
    input  wire lpfp_pkg::result_t q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lpfp_pkg::result_t      out_data
);
    import lpfp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // advance whenever the queue holds a result and the output register is empty or being taken
    assign q_pop      = q_not_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_data;
        end
    end

endmodule

`default_nettype wire
